// ----- hw/rtl/sgd_pkg.sv -----
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared widths, codes and beat types of the Sobel gradient/direction stream.
// ----------------------------------------------------------------------------
package sgd_pkg;

    localparam int PIX_W    = 8;
    localparam int MAX_LINE = 256;
    localparam int LINE_AW  = $clog2(MAX_LINE);
    localparam int POS_W    = 8;
    localparam int CFG_W    = 9;
    localparam int CFG_IW   = 1;
    localparam int GRAD_W   = 11;
    localparam int ABS_W    = GRAD_W - 1;

    localparam logic [CFG_W-1:0] DIM_MIN    = CFG_W'(4);
    localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_LINE);
    localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(256);

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] DIR_VERT  = 2'd0;
    localparam logic [1:0] DIR_HORIZ = 2'd1;
    localparam logic [1:0] DIR_OPP   = 2'd2;
    localparam logic [1:0] DIR_SAME  = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic [1:0]       direction;
        logic [POS_W-1:0] centre_row;
        logic [POS_W-1:0] centre_col;
    } res_beat_t;

    // line buffer write request: {row r-2 byte, row r-1 byte} per column
    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        logic [2*PIX_W-1:0] data;
    } lb_wr_t;

endpackage

// ----- hw/rtl/sgd_if.sv -----
// ----------------------------------------------------------------------------
// sgd_pix_if / sgd_res_if
// Valid/ready channels for pixel beats and result beats.
// ----------------------------------------------------------------------------
interface sgd_pix_if;
    logic              valid;
    logic              ready;
    sgd_pkg::pix_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sgd_res_if;
    logic              valid;
    logic              ready;
    sgd_pkg::res_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sobel_gradient_direction_stream.sv -----
// ----------------------------------------------------------------------------
// sobel_gradient_direction_stream
// Raster-order 3x3 Sobel edge stage: L1 magnitude and quantised direction.
// ----------------------------------------------------------------------------
// Pipeline: stage 1, stage 2 and result registers lie between a pixel beat and its result.
// Throughput: one pixel beat per cycle while the result side is ready and
//   no sweep runs; the whole pipe holds on an output stall (single global advance enable).
// Reset: position counters and valids clear at once; image size returns to
//   256x256; the line store is zeroed by a sweep (one column word per cycle)
//   during which no pixel beat is taken.
// ----------------------------------------------------------------------------
module sobel_gradient_direction_stream
(
    input  logic                         clk,
    input  logic                         rst_n,
    sgd_pix_if.sink                      pixels,
    sgd_res_if.source                    results,
    input  logic                         cfg_we,
    input  logic [sgd_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [sgd_pkg::CFG_W-1:0]    cfg_data
);

    localparam int PW  = sgd_pkg::PIX_W;
    localparam int QW  = sgd_pkg::POS_W;
    localparam int CW  = sgd_pkg::CFG_W;
    localparam int GW  = sgd_pkg::GRAD_W;
    localparam int AW  = sgd_pkg::LINE_AW;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;
    logic [CW-1:0] w_use;
    logic [CW-1:0] h_use;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(256);
            height_reg <= CW'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sgd_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                sgd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range sizes are clamped, not rejected
    always_comb
    begin
        w_use = width_reg;
        if (width_reg < sgd_pkg::DIM_MIN)
            w_use = sgd_pkg::DIM_MIN;
        else if (width_reg > sgd_pkg::WIDTH_MAX)
            w_use = sgd_pkg::WIDTH_MAX;
        h_use = height_reg;
        if (height_reg < sgd_pkg::DIM_MIN)
            h_use = sgd_pkg::DIM_MIN;
        else if (height_reg > sgd_pkg::HEIGHT_MAX)
            h_use = sgd_pkg::HEIGHT_MAX;
    end

    // ------------------------------------------------------------------
    // handshake: everything advances together when the output slot frees
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    logic lb_busy;
    logic accept;

    assign adv          = !out_valid_reg || results.ready;
    assign pixels.ready = adv && !lb_busy;
    assign accept       = pixels.valid && pixels.ready;

    // ------------------------------------------------------------------
    // stage 0: position of the incoming pixel, line store read
    // ------------------------------------------------------------------
    logic [QW-1:0] row_reg;
    logic [QW-1:0] col_reg;
    logic [QW-1:0] row_next;
    logic [QW-1:0] col_next;
    logic [QW-1:0] r0;
    logic [QW-1:0] c0;
    logic [QW-1:0] cr0;
    logic [QW-1:0] cc0;
    logic [CW-1:0] c_inc;
    logic [CW-1:0] r_inc;
    logic          emit0;
    logic          inner0;

    always_comb
    begin
        r0    = pixels.data.frame_start ? '0 : row_reg;
        c0    = pixels.data.frame_start ? '0 : col_reg;
        cr0   = r0 - 1'b1;
        cc0   = c0 - 1'b1;
        emit0 = (r0 != '0) && (c0 != '0);
        // interior centre: not in the first two or the last row/column
        inner0 = (cr0 >= QW'(2)) && (cc0 >= QW'(2))
              && ({1'b0, cr0} <= h_use - CW'(2))
              && ({1'b0, cc0} <= w_use - CW'(2));
        c_inc = {1'b0, c0} + CW'(1);
        r_inc = {1'b0, r0} + CW'(1);
        if (c_inc >= w_use)
        begin
            col_next = '0;
            row_next = (r_inc >= h_use) ? '0 : r_inc[QW-1:0];
        end
        else
        begin
            col_next = c_inc[QW-1:0];
            // a row already past a lowered height wraps here
            row_next = ({1'b0, r0} >= h_use) ? '0 : r0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: window assembly and gradients; line store write-back
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic [PW-1:0] s1_pixel_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_emit_reg;
    logic          s1_inner_reg;
    logic [QW-1:0] s1_crow_reg;
    logic [QW-1:0] s1_ccol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixels.data.pixel;
            s1_addr_reg  <= c0[AW-1:0];
            s1_emit_reg  <= emit0;
            s1_inner_reg <= inner0;
            s1_crow_reg  <= cr0;
            s1_ccol_reg  <= cc0;
        end
    end

    logic [2*PW-1:0]  lb_q;
    sgd_pkg::lb_wr_t  lb_wr;
    logic [PW-1:0]    top;
    logic [PW-1:0]    mid;
    logic             s1_fire;

    assign s1_fire = adv && s1_valid_reg;
    assign top     = lb_q[2*PW-1:PW];
    assign mid     = lb_q[PW-1:0];

    // older line moves up, new pixel becomes the previous line
    always_comb
    begin
        lb_wr.en   = s1_fire;
        lb_wr.addr = s1_addr_reg;
        lb_wr.data = {mid, s1_pixel_reg};
    end

    sgd_linebuf u_linebuf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (c0[AW-1:0]),
        .wr      (lb_wr),
        .rd_data (lb_q),
        .busy    (lb_busy)
    );

    // win_reg[0..2]: column c-2, win_reg[3..5]: column c-1 (top, mid, bottom)
    logic [PW-1:0] win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_fire)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    logic signed [GW-1:0] gx1;
    logic signed [GW-1:0] gy1;
    logic signed [GW-1:0] l0, l1, l2, m0, m2, q0, q1, q2;

    always_comb
    begin
        l0 = $signed({3'b000, win_reg[0]});
        l1 = $signed({3'b000, win_reg[1]});
        l2 = $signed({3'b000, win_reg[2]});
        m0 = $signed({3'b000, win_reg[3]});
        m2 = $signed({3'b000, win_reg[5]});
        q0 = $signed({3'b000, top});
        q1 = $signed({3'b000, mid});
        q2 = $signed({3'b000, s1_pixel_reg});
        gx1 = (q0 + (q1 <<< 1) + q2) - (l0 + (l1 <<< 1) + l2);
        gy1 = (l2 + (m2 <<< 1) + q2) - (l0 + (m0 <<< 1) + q0);
    end

    // ------------------------------------------------------------------
    // stage 2: magnitude and direction, only beats that produce a result
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    logic signed [GW-1:0] s2_gx_reg;
    logic signed [GW-1:0] s2_gy_reg;
    logic                 s2_inner_reg;
    logic [QW-1:0]        s2_crow_reg;
    logic [QW-1:0]        s2_ccol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_gx_reg    <= gx1;
            s2_gy_reg    <= gy1;
            s2_inner_reg <= s1_inner_reg;
            s2_crow_reg  <= s1_crow_reg;
            s2_ccol_reg  <= s1_ccol_reg;
        end
    end

    logic [PW-1:0] mag2;
    logic [1:0]    dir2;

    sgd_grad u_grad
    (
        .gx        (s2_gx_reg),
        .gy        (s2_gy_reg),
        .inner     (s2_inner_reg),
        .magnitude (mag2),
        .direction (dir2)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    sgd_pkg::res_beat_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            out_reg.magnitude  <= mag2;
            out_reg.direction  <= dir2;
            out_reg.centre_row <= s2_crow_reg;
            out_reg.centre_col <= s2_ccol_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        lb_busy |-> !pixels.ready)
        else $error("pixel taken during line store sweep");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !pixels.ready)
        else $error("pixel taken while result stalled");

    a_border_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_reg.centre_row < QW'(2)) || (out_reg.centre_col < QW'(2))))
        |-> ((out_reg.magnitude == '0) && (out_reg.direction == sgd_pkg::DIR_VERT)))
        else $error("border centre with non-zero result");

    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pixels.data.frame_start)
        |=> (s1_valid_reg && (s1_addr_reg == '0) && !s1_emit_reg))
        else $error("frame start not taken as origin");

endmodule

// ----- hw/rtl/sgd_linebuf.sv -----
// ----------------------------------------------------------------------------
// sgd_linebuf
// Two-line pixel store, one 16-bit word per column, with read bypass and a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module sgd_linebuf
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [sgd_pkg::LINE_AW-1:0]     rd_addr,
    input  sgd_pkg::lb_wr_t                 wr,
    output logic [2*sgd_pkg::PIX_W-1:0]     rd_data,
    output logic                            busy
);

    logic [2*sgd_pkg::PIX_W-1:0] mem [sgd_pkg::MAX_LINE];
    logic [2*sgd_pkg::PIX_W-1:0] q_reg;
    logic                        clr_reg;
    logic                        clr_next;
    logic [sgd_pkg::LINE_AW-1:0] clr_addr_reg;
    logic [sgd_pkg::LINE_AW-1:0] clr_addr_next;
    logic                        we;
    logic [sgd_pkg::LINE_AW-1:0] waddr;
    logic [2*sgd_pkg::PIX_W-1:0] wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg + 1'b1;
        clr_next      = clr_reg && (clr_addr_reg != {sgd_pkg::LINE_AW{1'b1}});
        we    = clr_reg || wr.en;
        waddr = clr_reg ? clr_addr_reg : wr.addr;
        wdata = clr_reg ? '0 : wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-to-read forwarding for same-column back-to-back beats
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (we && (waddr == rd_addr))
            begin
                q_reg <= wdata;
            end
            else
            begin
                q_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = q_reg;
    assign busy    = clr_reg;

endmodule

// ----- hw/rtl/sgd_grad.sv -----
// ----------------------------------------------------------------------------
// sgd_grad
// L1 magnitude with saturation and four-way direction code from gx, gy.
// ----------------------------------------------------------------------------
module sgd_grad
(
    input  logic signed [sgd_pkg::GRAD_W-1:0] gx,
    input  logic signed [sgd_pkg::GRAD_W-1:0] gy,
    input  logic                              inner,
    output logic [sgd_pkg::PIX_W-1:0]         magnitude,
    output logic [1:0]                        direction
);

    logic signed [sgd_pkg::GRAD_W-1:0] neg_x;
    logic signed [sgd_pkg::GRAD_W-1:0] neg_y;
    logic [sgd_pkg::ABS_W-1:0]         ax;
    logic [sgd_pkg::ABS_W-1:0]         ay;
    logic [sgd_pkg::GRAD_W-1:0]        sum;
    logic                              x_pos;
    logic                              x_neg;
    logic                              y_pos;
    logic                              y_neg;

    always_comb
    begin
        neg_x = -gx;
        neg_y = -gy;
        ax    = gx[sgd_pkg::GRAD_W-1] ? neg_x[sgd_pkg::ABS_W-1:0] : gx[sgd_pkg::ABS_W-1:0];
        ay    = gy[sgd_pkg::GRAD_W-1] ? neg_y[sgd_pkg::ABS_W-1:0] : gy[sgd_pkg::ABS_W-1:0];
        sum   = {1'b0, ax} + {1'b0, ay};
        x_neg = gx[sgd_pkg::GRAD_W-1];
        y_neg = gy[sgd_pkg::GRAD_W-1];
        x_pos = !x_neg && (gx != '0);
        y_pos = !y_neg && (gy != '0);

        magnitude = '0;
        direction = sgd_pkg::DIR_VERT;
        if (inner)
        begin
            magnitude = (sum > sgd_pkg::GRAD_W'(255)) ? {sgd_pkg::PIX_W{1'b1}}
                                                      : sum[sgd_pkg::PIX_W-1:0];
            if ({ax, 1'b0} < {1'b0, ay})
            begin
                direction = sgd_pkg::DIR_VERT;
            end
            else if ({1'b0, ax} > {ay, 1'b0})
            begin
                direction = sgd_pkg::DIR_HORIZ;
            end
            else if ((x_pos && y_neg) || (x_neg && y_pos))
            begin
                direction = sgd_pkg::DIR_OPP;
            end
            else
            begin
                direction = sgd_pkg::DIR_SAME;
            end
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sobel gradient/direction stream. A directed
// table of pixel beats, then phases of random frames under several image
// sizes and idle patterns; each result beat is compared with a typed table row's
// result or a local bit-exact predictor of the window arithmetic and position counters.
// ----------------------------------------------------------------------------
module tb_top;

    import sgd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int LIMIT_CYCLES  = 400_000;
    localparam int SETTLE_CYCLES = 8;        // settling wait for pixels that emit nothing
    localparam int HOLD_CYCLES   = 64;       // long result hold-off, fills the pipe
    localparam int DRAIN_LIMIT   = 2000;
    localparam int MAX_PRINTS    = 30;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    // one row of the directed table; typed rows carry their result written out
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
        bit               typed;
        bit               emits;
        res_beat_t        res;
    } stim_row_t;

    typedef struct {
        logic [CFG_W-1:0] width_val;
        logic [CFG_W-1:0] height_val;
        idle_mode_t       idle;
        int               beats;
        int               lead;       // beats sent first without a frame start
        bit               hold_off;
        bit               pause_mid;
    } phase_t;

    localparam res_beat_t NO_RES = '0;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    sgd_pix_if pix_if ();
    sgd_res_if res_if ();

    sobel_gradient_direction_stream dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: two previous lines, the two left window columns, the
    // position of the next pixel and the size registers as last written.
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] prev_line  [MAX_LINE];
    logic [PIX_W-1:0] prev2_line [MAX_LINE];
    logic [PIX_W-1:0] win_left   [3];          // column c-2, top to bottom
    logic [PIX_W-1:0] win_mid    [3];          // column c-1, top to bottom
    int unsigned      pos_row;
    int unsigned      pos_col;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    res_beat_t pending_results [$];

    int cycle_count    = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int beats_sent     = 0;
    int src_idle_pct   = 0;
    int snk_stall_pct  = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int sizes_run      = 0;

    // Directed table, 4x4 frames. Frame A: right column white, rest black, so
    // only centre (2,2) is inside the border and it sees a saturating
    // horizontal gradient. Frame B restarts mid-row 1 with a frame start and
    // is left to the predictor.
    stim_row_t directed_rows [24] = '{
        '{8'd0,   1'b1, 1'b1, 1'b0, NO_RES},                                // (0,0)
        '{8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
        '{8'd255, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'd0,   1'b0, 1'b1, 1'b0, NO_RES},                                // (1,0)
        '{8'd0,   1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd0, 8'd0}},
        '{8'd0,   1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd0, 8'd1}},
        '{8'd255, 1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd0, 8'd2}},
        '{8'd0,   1'b0, 1'b1, 1'b0, NO_RES},                                // (2,0)
        '{8'd0,   1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd1, 8'd0}},
        '{8'd0,   1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd1, 8'd1}},
        '{8'd255, 1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd1, 8'd2}},
        '{8'd0,   1'b0, 1'b1, 1'b0, NO_RES},                                // (3,0)
        '{8'd0,   1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd2, 8'd0}},
        '{8'd0,   1'b0, 1'b1, 1'b1, '{8'd0, DIR_VERT, 8'd2, 8'd1}},
        '{8'd255, 1'b0, 1'b1, 1'b1, '{8'd255, DIR_HORIZ, 8'd2, 8'd2}},      // saturates
        '{8'hA5,  1'b1, 1'b0, 1'b0, NO_RES},                                // frame B
        '{8'h5A,  1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFF,  1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00,  1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h81,  1'b0, 1'b0, 1'b0, NO_RES},                                // (1,0)
        '{8'h7E,  1'b1, 1'b0, 1'b0, NO_RES},                                // restart
        '{8'h3C,  1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hC3,  1'b0, 1'b0, 1'b0, NO_RES}
    };

    phase_t phases [8];

    // size register value as the block uses it
    function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] value,
                                               input logic [CFG_W-1:0] top);
        if (value < DIM_MIN)
            return DIM_MIN;
        if (value > top)
            return top;
        return value;
    endfunction

    // One pixel beat through the predictor: updates the line and window
    // state and the position, and says whether a result beat follows.
    function automatic void predict_sobel(input logic [PIX_W-1:0] px, input logic fs,
                                          output bit emits, output res_beat_t res);
        int unsigned w, h, r, c, idx, cr, cc;
        int          l0, l1, l2, m0, m2, r0, r1, r2;
        int          gx, gy, ax, ay, sum;
        logic [PIX_W-1:0] top, mid;
        w = dim_in_use(width_reg, WIDTH_MAX);
        h = dim_in_use(height_reg, HEIGHT_MAX);
        if (fs)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        r   = pos_row;
        c   = pos_col;
        idx = c % MAX_LINE;
        top = prev2_line[idx];
        mid = prev_line[idx];
        prev2_line[idx] = mid;
        prev_line[idx]  = px;

        emits = (r >= 1) && (c >= 1);
        res   = '0;
        if (emits)
        begin
            cr = r - 1;
            cc = c - 1;
            res.centre_row = POS_W'(cr);
            res.centre_col = POS_W'(cc);
            res.direction  = DIR_VERT;
            // only centres clear of the border get real gradients
            if (cr >= 2 && cc >= 2 && cr <= h - 2 && cc <= w - 2)
            begin
                l0 = int'(win_left[0]);
                l1 = int'(win_left[1]);
                l2 = int'(win_left[2]);
                m0 = int'(win_mid[0]);
                m2 = int'(win_mid[2]);
                r0 = int'(top);
                r1 = int'(mid);
                r2 = int'(px);
                gx  = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
                gy  = (l2 + 2 * m2 + r2) - (l0 + 2 * m0 + r0);
                ax  = (gx < 0) ? -gx : gx;
                ay  = (gy < 0) ? -gy : gy;
                sum = ax + ay;
                res.magnitude = (sum > 255) ? 8'd255 : PIX_W'(sum);
                if (2 * ax < ay)
                    res.direction = DIR_VERT;
                else if (ax > 2 * ay)
                    res.direction = DIR_HORIZ;
                else if ((gx > 0 && gy < 0) || (gx < 0 && gy > 0))
                    res.direction = DIR_OPP;
                else
                    res.direction = DIR_SAME;
            end
        end

        win_left = win_mid;
        win_mid[0] = top;
        win_mid[1] = mid;
        win_mid[2] = px;

        // a position past a freshly lowered limit wraps on this step
        if (c + 1 >= w)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            pos_col = c + 1;
            pos_row = (r >= h) ? 0 : r;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // register write; the predictor takes the new value at once, the bench
    // only writes while nothing is in flight
    task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    // Offer one pixel beat, with random idle cycles ahead of it. Valid stays
    // high after acceptance, so back-to-back beats follow without a gap.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs, input bit typed,
                              input bit typed_emits, input res_beat_t typed_res);
        bit        emits;
        res_beat_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= '{pixel: px, frame_start: fs};
        do
            @(posedge clk);
        while (pix_if.ready !== 1'b1);
        predict_sobel(px, fs, emits, res);
        if (typed)
        begin
            emits = typed_emits;
            res   = typed_res;
        end
        if (emits)
            pending_results.push_back(res);
        beats_sent++;
    endtask

    // Mostly whole frames with random content; one in ten is cut short and
    // one in ten is a burst of pixels with stray frame starts.
    task automatic stream_frames(input int n_beats, input int lead);
        int               left, len, k, flavour, style;
        logic [PIX_W-1:0] base, px;
        for (k = 0; k < lead; k++)
            send_pixel(PIX_W'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_RES);
        left = n_beats - lead;
        while (left > 0)
        begin
            flavour = $urandom_range(9);
            style   = $urandom_range(2);
            base    = PIX_W'($urandom_range(240));
            len     = dim_in_use(width_reg, WIDTH_MAX) * dim_in_use(height_reg, HEIGHT_MAX);
            if (flavour == 0)
                len = $urandom_range(len, 1);
            else if (flavour == 1)
                len = 6;
            if (len > left)
                len = left;
            for (k = 0; k < len; k++)
            begin
                case (style)
                    0:       px = PIX_W'($urandom_range(255));
                    1:       px = $urandom_range(1) ? 8'd255 : 8'd0;   // hard edges
                    default: px = base + PIX_W'($urandom_range(15));   // soft, unsaturated
                endcase
                if (flavour == 1)
                    send_pixel(px, 1'($urandom_range(1)), 1'b0, 1'b0, NO_RES);
                else
                    send_pixel(px, k == 0, 1'b0, 1'b0, NO_RES);
            end
            left -= len;
        end
    endtask

    // nothing outstanding, then a settling wait for pixels that emit nothing
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready pattern per phase, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    initial
    begin : result_ready_drive
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_asked;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // every accepted result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        res_beat_t want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat for centre (%0d,%0d) with none pending",
                                          res_if.data.centre_row, res_if.data.centre_col));
            else
            begin
                want = pending_results.pop_front();
                if (res_if.data.centre_row !== want.centre_row)
                    report_mismatch($sformatf("centre_row %0d, expected %0d",
                                              res_if.data.centre_row, want.centre_row));
                if (res_if.data.centre_col !== want.centre_col)
                    report_mismatch($sformatf("centre_col %0d, expected %0d",
                                              res_if.data.centre_col, want.centre_col));
                if (res_if.data.magnitude !== want.magnitude)
                    report_mismatch($sformatf("centre (%0d,%0d) magnitude %0d, expected %0d",
                                              want.centre_row, want.centre_col,
                                              res_if.data.magnitude, want.magnitude));
                if (res_if.data.direction !== want.direction)
                    report_mismatch($sformatf("centre (%0d,%0d) direction %0d, expected %0d",
                                              want.centre_row, want.centre_col,
                                              res_if.data.direction, want.direction));
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d results pending",
                 pending_results.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int i, p, half;
        pix_if.valid <= 1'b0;
        pix_if.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        rst_n        <= 1'b0;

        // predictor matches the block after reset: zeroed store, 256x256
        for (i = 0; i < MAX_LINE; i++)
        begin
            prev_line[i]  = '0;
            prev2_line[i] = '0;
        end
        for (i = 0; i < 3; i++)
        begin
            win_left[i] = '0;
            win_mid[i]  = '0;
        end
        pos_row    = 0;
        pos_col    = 0;
        width_reg  = CFG_W'(256);
        height_reg = CFG_W'(256);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // the line store clearing sweep just holds off the first pixel beat
        write_reg(REG_IMAGE_WIDTH, CFG_W'(4));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
        sizes_run++;
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].pixel, directed_rows[i].frame_start,
                       directed_rows[i].typed, directed_rows[i].emits, directed_rows[i].res);
        pix_if.valid <= 1'b0;

        // Phases: small frames; clamped wide run (256 x 4 from 511 x 0); a
        // lowered width picking up from a high column; a frame wider than 128
        // for the upper line store half; both limits at 256 exactly; random
        // small sizes, the last ones possibly below the clamp.
        phases[0] = '{CFG_W'(4),   CFG_W'(4),   IDLE_NONE, 120, 0,  1'b1, 1'b0};
        phases[1] = '{CFG_W'(7),   CFG_W'(5),   IDLE_SRC,  110, 0,  1'b0, 1'b0};
        phases[2] = '{CFG_W'(511), CFG_W'(0),   IDLE_NONE, 270, 0,  1'b0, 1'b0};
        phases[3] = '{CFG_W'(3),   CFG_W'(256), IDLE_SNK,  60,  60, 1'b0, 1'b0};
        phases[4] = '{CFG_W'(130), CFG_W'(4),   IDLE_BOTH, 520, 0,  1'b0, 1'b0};
        phases[5] = '{CFG_W'(256), CFG_W'(257), IDLE_NONE, 40,  8,  1'b0, 1'b0};
        phases[6] = '{CFG_W'($urandom_range(12, 4)), CFG_W'($urandom_range(12, 4)),
                      IDLE_BOTH, 100, 0, 1'b0, 1'b1};
        phases[7] = '{CFG_W'($urandom_range(9, 0)), CFG_W'($urandom_range(9, 0)),
                      IDLE_SNK, 60, 0, 1'b0, 1'b0};

        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            write_reg(REG_IMAGE_WIDTH, phases[p].width_val);
            write_reg(REG_IMAGE_HEIGHT, phases[p].height_val);
            sizes_run++;
            src_idle_pct  = (phases[p].idle == IDLE_SRC)  ? 79 :
                            (phases[p].idle == IDLE_BOTH) ? 27 : 0;
            snk_stall_pct = (phases[p].idle == IDLE_SNK)  ? 79 :
                            (phases[p].idle == IDLE_BOTH) ? 27 : 0;
            // long result stall while pixels keep coming: input must back up
            if (phases[p].hold_off)
                hold_asked++;
            if (phases[p].pause_mid)
            begin
                half = phases[p].beats / 2;
                stream_frames(half, phases[p].lead);
                pix_if.valid <= 1'b0;
                // sender waits for every outstanding result before going on
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
                stream_frames(phases[p].beats - half, 0);
            end
            else
                stream_frames(phases[p].beats, phases[p].lead);
            pix_if.valid <= 1'b0;
        end

        // drain, then a tail to catch any stray beats
        for (i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      pending_results.size()));

        $display("%0d pixel beats over %0d image sizes, %0d result beats checked",
                 beats_sent, sizes_run, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sobel_gradient_direction_stream.f -----
hw/rtl/sgd_pkg.sv
hw/rtl/sgd_if.sv
hw/rtl/sgd_linebuf.sv
hw/rtl/sgd_grad.sv
hw/rtl/sobel_gradient_direction_stream.sv
bench/tb_top.sv
